// ===== hdl/esg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esg_pkg
// shared constants, types and the quarter-wave sine table of the sweep
// generator
// ----------------------------------------------------------------------------
package esg_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int QUARTER_BITS    = SINE_TABLE_BITS - 2;
  localparam int QUARTER         = 1 << QUARTER_BITS;

  localparam int LENGTH_BITS     = 20;
  localparam int IDX_BITS        = LENGTH_BITS + 2;

  localparam int SAMPLE_BITS     = 16;
  localparam int PHASE_BITS      = 32;
  localparam int INC_FRAC_BITS   = 16;
  localparam int INC_BITS        = PHASE_BITS + INC_FRAC_BITS;
  localparam int START_INC_BITS  = 31;
  localparam int GROWTH_BITS     = 32;
  localparam int GROWTH_FRAC_BITS = 30;
  localparam int INC_SPLIT       = 24;

  localparam int CFG_INDEX_BITS  = 3;
  localparam int CFG_DATA_BITS   = 32;

  localparam int QUEUE_PTR_BITS  = 2;
  localparam int QUEUE_DEPTH     = 1 << QUEUE_PTR_BITS;
  localparam int QUEUE_CNT_BITS  = QUEUE_PTR_BITS + 1;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam int TAYLOR_TERMS = 12;
  localparam logic [63:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_LEAD_PAD  = 3'd0,
    CFG_SWEEP     = 3'd1,
    CFG_PAD_END   = 3'd2,
    CFG_START_INC = 3'd3,
    CFG_GROWTH    = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [LENGTH_BITS-1:0]    lead_pad;
    logic [LENGTH_BITS-1:0]    sweep;
    logic [LENGTH_BITS-1:0]    pad_end;
    logic [START_INC_BITS-1:0] start_inc;
    logic [GROWTH_BITS-1:0]    growth;
  } esg_cfg_t;

  // one classified request between front and back
  typedef struct packed {
    logic start;
    logic sweep;
    logic last;
  } esg_cmd_t;

  typedef logic [QUARTER-1:0][SAMPLE_BITS-1:0] sine_tab_t;

  // round(32767*sin(2*pi*r/N)) by truncated q30 taylor series
  function automatic logic [SAMPLE_BITS-1:0] quarter_sine(input logic [63:0] r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    x    = (PI_Q30 * r * 64'd2) >> SINE_TABLE_BITS;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    for (int n = 1; n <= TAYLOR_TERMS; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
      if ((n & 1) != 0) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > 64'sd1073741824) begin
      sum = 64'sd1073741824;
    end
    v = (sum * 64'sd32767 + 64'sd536870912) >>> 30;
    if (v > 64'sd32767) begin
      v = 64'sd32767;
    end
    return v[SAMPLE_BITS-1:0];
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t t;
    for (int i = 0; i < QUARTER; i++) begin
      t[i] = quarter_sine(64'(i));
    end
    return t;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();
  localparam logic [SAMPLE_BITS-1:0] SINE_AT_QUARTER = quarter_sine(64'(QUARTER));

endpackage

// ===== hdl/esg_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esg_front
// accepts requests, tracks the sample index and classifies each request
// ----------------------------------------------------------------------------
module esg_front (
  input  logic              clk,
  input  logic              rst_n,
  input  esg_pkg::esg_cfg_t cfg,
  input  logic              push,
  input  logic              restart,
  output logic              full,
  output logic              cmd_push,
  output esg_pkg::esg_cmd_t cmd,
  input  logic              cmd_full
);
  import esg_pkg::*;

  logic [IDX_BITS-1:0] idx_r, idx_nxt;
  logic [IDX_BITS-1:0] pb, sweep_end, total, eff;
  logic                accept, zero_total;

  assign accept   = push && !cmd_full;
  assign full     = cmd_full;
  assign cmd_push = accept;

  always_comb begin
    pb         = IDX_BITS'(cfg.lead_pad);
    sweep_end  = pb + IDX_BITS'(cfg.sweep);
    total      = sweep_end + IDX_BITS'(cfg.pad_end);
    zero_total = (total == '0);
    cmd.start  = restart || (idx_r >= total);
    eff        = cmd.start ? '0 : idx_r;
    if (zero_total) begin
      cmd.sweep = 1'b0;
      cmd.last  = 1'b1;
    end else begin
      cmd.sweep = (eff >= pb) && (eff < sweep_end);
      cmd.last  = (eff == total - IDX_BITS'(1));
    end
    // the back reloads phase and increment on the last sample
    if (cmd.last) begin
      idx_nxt = '0;
    end else begin
      idx_nxt = eff + IDX_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (accept) begin
      idx_r <= idx_nxt;
    end
  end

endmodule

// ===== hdl/esg_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esg_queue
// short request queue that decouples the front from the back
// ----------------------------------------------------------------------------
module esg_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  esg_pkg::esg_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output esg_pkg::esg_cmd_t pop_cmd,
  output logic              empty
);
  import esg_pkg::*;

  esg_cmd_t                  mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_CNT_BITS-1:0] count_r, count_nxt;
  logic                      do_push, do_pop;

  assign full    = (count_r == QUEUE_CNT_BITS'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + QUEUE_CNT_BITS'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QUEUE_CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QUEUE_PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QUEUE_PTR_BITS'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ===== hdl/esg_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esg_back
// phase and increment recursion, sine lookup and the result queue
// ----------------------------------------------------------------------------
module esg_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  esg_pkg::esg_cfg_t                    cfg,
  input  esg_pkg::esg_cmd_t                    cmd,
  input  logic                                 cmd_empty,
  output logic                                 cmd_pop,
  input  logic                                 out_pop,
  output logic                                 out_empty,
  output logic signed [esg_pkg::SAMPLE_BITS-1:0] out_sample,
  output logic                                 out_last
);
  import esg_pkg::*;

  localparam int PROD_BITS     = INC_SPLIT + GROWTH_BITS;
  localparam int GROW_SHIFT    = GROWTH_FRAC_BITS - INC_SPLIT;
  localparam int GROW_RES_BITS = PROD_BITS + 1 - GROW_SHIFT;

  logic [PHASE_BITS-1:0] phase_r, phase_nxt, ph_use;
  logic [INC_BITS-1:0]   inc_r, inc_nxt, inc_use, inc_grown, inc_start;

  logic [PROD_BITS-1:0]     prod_lo, prod_hi;
  logic [PROD_BITS:0]       grow_sum;
  logic [GROW_RES_BITS-1:0] grow_res;

  logic [SINE_TABLE_BITS-1:0] k;
  logic [QUARTER_BITS-1:0]    r;
  logic [SAMPLE_BITS-1:0]     mag, sample_val;

  logic [SAMPLE_BITS-1:0]    smp_mem [QUEUE_DEPTH];
  logic                      last_mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_CNT_BITS-1:0] count_r, count_nxt;
  logic                      out_full, do_out_pop;

  assign out_full   = (count_r == QUEUE_CNT_BITS'(QUEUE_DEPTH));
  assign out_empty  = (count_r == '0);
  assign do_out_pop = out_pop && !out_empty;
  assign cmd_pop    = !cmd_empty && !out_full;
  assign out_sample = signed'(smp_mem[rd_ptr_r]);
  assign out_last   = last_mem[rd_ptr_r];

  // start of sequence overrides the running state
  always_comb begin
    inc_start = {{(INC_BITS-START_INC_BITS-INC_FRAC_BITS){1'b0}},
                 cfg.start_inc, {INC_FRAC_BITS{1'b0}}};
    ph_use    = cmd.start ? '0 : phase_r;
    inc_use   = cmd.start ? inc_start : inc_r;
  end

  // increment times growth, two partial products, q30 truncation
  always_comb begin
    prod_lo  = PROD_BITS'(inc_use[INC_SPLIT-1:0]) * PROD_BITS'(cfg.growth);
    prod_hi  = PROD_BITS'(inc_use[INC_BITS-1:INC_SPLIT]) * PROD_BITS'(cfg.growth);
    grow_sum = {1'b0, prod_hi} + (PROD_BITS+1)'(prod_lo >> INC_SPLIT);
    grow_res = GROW_RES_BITS'(grow_sum >> GROW_SHIFT);
    if (|grow_res[GROW_RES_BITS-1:INC_BITS]) begin
      inc_grown = '1;
    end else begin
      inc_grown = grow_res[INC_BITS-1:0];
    end
  end

  // quarter-wave table with mirror and sign
  always_comb begin
    k = ph_use[PHASE_BITS-1 -: SINE_TABLE_BITS];
    r = k[QUARTER_BITS-1:0];
    if (k[QUARTER_BITS]) begin
      if (r == '0) begin
        mag = SINE_AT_QUARTER;
      end else begin
        mag = SINE_TAB[QUARTER_BITS'(-r)];
      end
    end else begin
      mag = SINE_TAB[r];
    end
    sample_val = k[QUARTER_BITS+1] ? -mag : mag;
  end

  // the last sample rewinds to the start with the start increment of now
  always_comb begin
    if (cmd.last) begin
      phase_nxt = '0;
      inc_nxt   = inc_start;
    end else if (cmd.sweep) begin
      phase_nxt = ph_use + inc_use[INC_BITS-1:INC_FRAC_BITS];
      inc_nxt   = inc_grown;
    end else begin
      phase_nxt = ph_use;
      inc_nxt   = inc_use;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd_pop && !do_out_pop) begin
      count_nxt = count_r + QUEUE_CNT_BITS'(1);
    end else if (do_out_pop && !cmd_pop) begin
      count_nxt = count_r - QUEUE_CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      smp_mem[wr_ptr_r]  <= cmd.sweep ? sample_val : '0;
      last_mem[wr_ptr_r] <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= '0;
      inc_r    <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (cmd_pop) begin
        phase_r  <= phase_nxt;
        inc_r    <= inc_nxt;
        wr_ptr_r <= wr_ptr_r + QUEUE_PTR_BITS'(1);
      end
      if (do_out_pop) begin
        rd_ptr_r <= rd_ptr_r + QUEUE_PTR_BITS'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ===== hdl/exponential_sine_sweep_generator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exponential_sine_sweep_generator_unit
// padded exponential sine sweep source with queue-style request and result
// ports
// ----------------------------------------------------------------------------
// Every accepted request (in_push while in_full is low) yields one signed
// q1.15 sample: leading-pad zeros, sweep_samples sweep samples, pad_end zeros,
// with out_last set on the final one, after which the sequence wraps and
// reloads the start increment in force at that moment.
// in_restart returns the sequence to its first sample before that request is
// served. The block takes one request per cycle while in_full is low and
// returns one result per cycle while the result queue has room; the figure
// is set by the increment recursion, which runs through two 24x32 partial
// products of the increment and the growth factor. A result passes through
// the request queue and the result queue before it shows on the out_ ports.
// A front stage keeps the sample index and classifies each request
// (padding or sweep, start of sequence, last), a four-entry queue carries the
// classified requests, and a back stage runs the phase and increment
// recursion and the quarter-wave sine table into a four-entry result queue.
// Configuration writes (cfg_valid, always ready) go to register index 0 to 4:
// leading pad, sweep length, pad end, start increment, growth (q2.30); other
// indexes are ignored. Write them only while no request is in flight.
// ----------------------------------------------------------------------------
module exponential_sine_sweep_generator_unit (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_push,
  output logic                                    in_full,
  input  logic                                    in_restart,
  output logic                                    out_empty,
  input  logic                                    out_pop,
  output logic signed [esg_pkg::SAMPLE_BITS-1:0]  out_sample,
  output logic                                    out_last,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [esg_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
  input  logic [esg_pkg::CFG_DATA_BITS-1:0]       cfg_data
);
  import esg_pkg::*;

  esg_cfg_t cfg_r;
  esg_cmd_t front_cmd, back_cmd;
  logic     front_push, q_full, q_empty, back_pop;

  // config port never stalls
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lead_pad  <= '0;
      cfg_r.sweep     <= LENGTH_BITS'(1);
      cfg_r.pad_end   <= '0;
      cfg_r.start_inc <= '0;
      cfg_r.growth    <= GROWTH_BITS'(1) << GROWTH_FRAC_BITS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LEAD_PAD:  cfg_r.lead_pad  <= cfg_data[LENGTH_BITS-1:0];
        CFG_SWEEP:     cfg_r.sweep     <= cfg_data[LENGTH_BITS-1:0];
        CFG_PAD_END:   cfg_r.pad_end   <= cfg_data[LENGTH_BITS-1:0];
        CFG_START_INC: cfg_r.start_inc <= cfg_data[START_INC_BITS-1:0];
        CFG_GROWTH:    cfg_r.growth    <= cfg_data[GROWTH_BITS-1:0];
        default: ;
      endcase
    end
  end

  // front: index tracking and classification
  esg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .push     (in_push),
    .restart  (in_restart),
    .full     (in_full),
    .cmd_push (front_push),
    .cmd      (front_cmd),
    .cmd_full (q_full)
  );

  // classified requests between the two halves
  esg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (front_push),
    .push_cmd (front_cmd),
    .full     (q_full),
    .pop      (back_pop),
    .pop_cmd  (back_cmd),
    .empty    (q_empty)
  );

  // back: oscillator recursion and result queue
  esg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .cmd        (back_cmd),
    .cmd_empty  (q_empty),
    .cmd_pop    (back_pop),
    .out_pop    (out_pop),
    .out_empty  (out_empty),
    .out_sample (out_sample),
    .out_last   (out_last)
  );

endmodule
